[rtl/cicd_pkg.sv]
// shared constants and types for the cloud-in-cell charge deposit block
package cicd_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int POS_BITS    = 23;
	localparam int GRID_BITS   = 7;
	localparam int GRID_CELLS  = 1 << GRID_BITS;
	localparam int CELL_BITS   = 2 * GRID_BITS;
	localparam int CHARGE_BITS = 16;
	localparam int OUT_BITS    = 32;

	// stream payload layout
	localparam int IN_DATA_BITS  = 64;
	localparam int OUT_DATA_BITS = 32;
	localparam int POS_X_LSB     = 0;
	localparam int POS_Y_LSB     = POS_X_LSB + POS_BITS;
	localparam int ROW_LSB       = POS_Y_LSB + POS_BITS;
	localparam int COL_LSB       = ROW_LSB + GRID_BITS;

	// weight and product widths
	localparam int W_BITS     = FRAC_BITS + 1;
	localparam int P1_BITS    = 2 * FRAC_BITS + 1;
	localparam int P2_BITS    = P1_BITS + CHARGE_BITS;
	localparam int SHIFT      = FRAC_BITS + CHARGE_BITS;
	localparam int SHARE_BITS = P2_BITS - SHIFT;

	localparam logic [CHARGE_BITS-1:0] CHARGE_RESET = 16'd655;

	localparam logic MODE_DEPOSIT = 1'b0;
	localparam logic MODE_READ    = 1'b1;

	typedef logic [GRID_BITS-1:0] grid_idx_t;
	typedef logic [CELL_BITS-1:0] cell_addr_t;
	typedef logic [FRAC_BITS-1:0] frac_t;

endpackage

[rtl/cloud_in_cell_charge_deposit.sv]
// top level: bilinear charge deposit into a cell memory with read-and-clear
//
//  channel   | direction | payload
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | tdata: pos_x, pos_y, cell_row, cell_col; tuser: mode
//  m_axis    | out       | tdata: cell_value; tuser: overflow_seen
//  cfg_wr    | in        | particle_charge, written when cfg_wr_en is high
//
// a deposit makes four corner read-modify-writes through the single
// read port and single write port of the grid memory, plus two stages of
// multiply and accumulate; a read is a memory read, then write-back of zero.
// after reset a clearing pass writes zero to all 16384 cells, one per cycle,
// with s_axis_tready low. a read stalls only while the output register is full.
module cloud_in_cell_charge_deposit #(
	parameter int ACC_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [22:0] pos_x, [45:23] pos_y, [52:46] cell_row, [59:53] cell_col, [63:60] zero
	input  logic [cicd_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
	// [0] mode
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [31:0] cell_value
	output logic [cicd_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
	// [0] overflow_seen
	output logic                                 m_axis_tuser,
	input  logic                                 cfg_wr_en,
	input  logic [cicd_pkg::CHARGE_BITS-1:0]     cfg_wr_data
);
	import cicd_pkg::*;

	localparam int SUM_BITS = ((ACC_BITS > SHARE_BITS) ? ACC_BITS : SHARE_BITS) + 1;
	localparam int EXT_BITS = (ACC_BITS > OUT_BITS) ? ACC_BITS : OUT_BITS;
	localparam int NCELLS   = GRID_CELLS * GRID_CELLS;
	localparam logic [W_BITS-1:0] W_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DEP,
		ST_DRAIN,
		ST_RD1,
		ST_RD2
	} state_t;

	state_t                  state_q;
	cell_addr_t              clr_cnt_q;
	logic [1:0]              corner_q;
	logic [CHARGE_BITS-1:0]  charge_q;
	logic                    ovf_q;
	logic                    m_vld_q;
	logic [OUT_BITS-1:0]     m_data_q;
	logic                    m_user_q;

	// captured item
	frac_t                   fx_q, fy_q;
	grid_idx_t               xlo_q, ylo_q;
	cell_addr_t              rd_addr_q;

	// pipeline
	logic                    v1_s1, v2_s2;
	logic [P1_BITS-1:0]      p1_s1;
	cell_addr_t              addr_s1, addr_s2;
	logic [P2_BITS-1:0]      p2_s2;

	// memory
	logic [ACC_BITS-1:0]     grid_mem [NCELLS];
	logic [ACC_BITS-1:0]     mem_rdata_q;
	logic                    mem_we, mem_re;
	cell_addr_t              mem_waddr, mem_raddr;
	logic [ACC_BITS-1:0]     mem_wdata;

	logic                    in_acc, out_free;
	logic [W_BITS-1:0]       wx, wy;
	logic [2*W_BITS-1:0]     p1_full;
	logic [P2_BITS-1:0]      p2_full;
	grid_idx_t               cx, cy;
	logic [SUM_BITS-1:0]     sum_w;
	logic                    sat;
	logic [EXT_BITS-1:0]     rd_ext;
	logic [OUT_BITS-1:0]     rd_clamp;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_vld_q || m_axis_tready;
	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// corner order: (lo,lo) (lo,hi) (hi,lo) (hi,hi)
	always_comb begin
		wx      = corner_q[1] ? {1'b0, fx_q} : W_ONE - {1'b0, fx_q};
		wy      = corner_q[0] ? {1'b0, fy_q} : W_ONE - {1'b0, fy_q};
		cx      = corner_q[1] ? xlo_q + 1'b1 : xlo_q;
		cy      = corner_q[0] ? ylo_q + 1'b1 : ylo_q;
		p1_full = wx * wy;
		p2_full = p1_s1 * charge_q;
	end

	// rounding bit enters as carry
	always_comb begin
		sum_w = SUM_BITS'(mem_rdata_q) + SUM_BITS'(p2_s2[P2_BITS-1:SHIFT])
			+ SUM_BITS'(p2_s2[SHIFT-1]);
		sat   = sum_w > SUM_BITS'({ACC_BITS{1'b1}});
	end

	always_comb begin
		rd_ext   = EXT_BITS'(mem_rdata_q);
		rd_clamp = (rd_ext > EXT_BITS'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}}
			: rd_ext[OUT_BITS-1:0];
	end

	always_comb begin
		mem_re    = v1_s1 || (state_q == ST_RD1);
		mem_raddr = (state_q == ST_RD1) ? rd_addr_q : addr_s1;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		priority if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (v2_s2) begin
			mem_we    = 1'b1;
			mem_waddr = addr_s2;
			mem_wdata = sat ? {ACC_BITS{1'b1}} : sum_w[ACC_BITS-1:0];
		end else if (state_q == ST_RD2 && out_free) begin
			mem_we    = 1'b1;
			mem_waddr = rd_addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= grid_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			corner_q  <= '0;
			charge_q  <= CHARGE_RESET;
			ovf_q     <= 1'b0;
			m_vld_q   <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				charge_q <= cfg_wr_data;
			end
			// in ST_RD2 the output register is reloaded instead
			if (m_vld_q && m_axis_tready && state_q != ST_RD2) begin
				m_vld_q <= 1'b0;
			end
			if (v2_s2 && sat) begin
				ovf_q <= 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (&clr_cnt_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						corner_q <= '0;
						state_q  <= (s_axis_tuser == MODE_READ) ? ST_RD1 : ST_DEP;
					end
				end
				ST_DEP: begin
					corner_q <= corner_q + 1'b1;
					if (&corner_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v1_s1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					// hold until the output register can take the cell
					if (out_free) begin
						m_vld_q  <= 1'b1;
						m_data_q <= rd_clamp;
						m_user_q <= ovf_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			v1_s1 <= (state_q == ST_DEP);
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		p1_s1   <= p1_full[P1_BITS-1:0];
		addr_s1 <= {cx, cy};
		p2_s2   <= p2_full;
		addr_s2 <= addr_s1;
	end

	// the integer part fills the cell index exactly; the upper cell wraps at the grid edge
	always_ff @(posedge clk) begin
		if (in_acc) begin
			fx_q      <= s_axis_tdata[POS_X_LSB +: FRAC_BITS];
			fy_q      <= s_axis_tdata[POS_Y_LSB +: FRAC_BITS];
			xlo_q     <= s_axis_tdata[POS_X_LSB + FRAC_BITS +: GRID_BITS];
			ylo_q     <= s_axis_tdata[POS_Y_LSB + FRAC_BITS +: GRID_BITS];
			rd_addr_q <= {s_axis_tdata[ROW_LSB +: GRID_BITS], s_axis_tdata[COL_LSB +: GRID_BITS]};
		end
	end

endmodule

[rtl/cicd_checker.sv]
// port-level checks for the charge deposit block, bound to the top level
module cicd_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic                                 s_axis_tuser,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [cicd_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
	input logic                                 m_axis_tuser
);
	import cicd_pkg::*;

	logic ovf_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_seen_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser) begin
			ovf_seen_q <= 1'b1;
		end
	end

	// clearing pass holds off input right after reset
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !s_axis_tready)
		else $error("input ready during clearing pass");

	// one item at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a transaction");

	// a result only follows a read transaction, through the read and write-back states
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
			$past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_READ), 3))
		else $error("result without a read transaction");

	// the overflow flag is sticky
	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ovf_seen_q |-> m_axis_tuser)
		else $error("overflow flag cleared");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output changed");

endmodule

bind cloud_in_cell_charge_deposit cicd_checker u_cicd_checker (.*);

[tb/sv/cloud_in_cell_charge_deposit_test.sv]
// self-checking testbench for the cloud-in-cell charge deposit block
module cloud_in_cell_charge_deposit_test;

	import cicd_pkg::*;

	typedef struct packed {
		logic             mode;
		logic [22:0]      pos_x;
		logic [22:0]      pos_y;
		grid_idx_t        cell_row;
		grid_idx_t        cell_col;
	} particle_item_t;

	typedef struct packed {
		logic [31:0] cell_value;
		logic        overflow_seen;
	} cell_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
	logic                      s_axis_tuser = 1'b0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
	logic                      m_axis_tuser;
	logic                      cfg_wr_en = 1'b0;
	logic [CHARGE_BITS-1:0]    cfg_wr_data = '0;

	// own copy of the grid, the sticky flag and the charge register
	logic [31:0]               cell_charge [0:GRID_CELLS*GRID_CELLS-1];
	logic                      overflow_model = 1'b0;
	logic [CHARGE_BITS-1:0]    charge_setting = CHARGE_RESET;

	particle_item_t            pending_particles [$];
	cell_result_t              expected_cells [$];
	particle_item_t            next_item;
	cell_result_t              want;

	int issued_items = 0;
	int accepted_items = 0;
	int deposits_seen = 0;
	int reads_checked = 0;
	int mismatches = 0;
	int charge_settings = 1;
	int send_gap = 0;
	int send_quiet = 0;
	int stall_left = 0;
	int ready_quiet = 0;

	cloud_in_cell_charge_deposit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < GRID_CELLS*GRID_CELLS; i++)
			cell_charge[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [32:0] cell_share(logic [16:0] wa, logic [16:0] wb);
		logic [63:0] prod;
		prod = 64'(wa) * 64'(wb) * 64'(charge_setting);
		return 33'((prod + (64'd1 << (FRAC_BITS + 15))) >> (FRAC_BITS + 16));
	endfunction

	function automatic void add_to_cell(grid_idx_t row, grid_idx_t col, logic [32:0] amount);
		logic [32:0] sum;
		sum = {1'b0, cell_charge[{row, col}]} + amount;
		if (sum > 33'hFFFF_FFFF) begin
			sum = 33'hFFFF_FFFF;
			overflow_model = 1'b1;
		end
		cell_charge[{row, col}] = sum[31:0];
	endfunction

	function automatic void deposit_particle(logic [22:0] px, logic [22:0] py);
		grid_idx_t   xlo, ylo, xhi, yhi;
		logic [16:0] fx, fy, wxl, wyl;
		xlo = px[FRAC_BITS +: GRID_BITS];
		ylo = py[FRAC_BITS +: GRID_BITS];
		xhi = xlo + 1'b1;
		yhi = ylo + 1'b1;
		fx = {1'b0, px[FRAC_BITS-1:0]};
		fy = {1'b0, py[FRAC_BITS-1:0]};
		wxl = 17'h10000 - fx;
		wyl = 17'h10000 - fy;
		add_to_cell(xlo, ylo, cell_share(wxl, wyl));
		add_to_cell(xlo, yhi, cell_share(wxl, fy));
		add_to_cell(xhi, ylo, cell_share(fx, wyl));
		add_to_cell(xhi, yhi, cell_share(fx, fy));
	endfunction

	function automatic void read_and_clear(grid_idx_t row, grid_idx_t col);
		cell_result_t r;
		r.cell_value = cell_charge[{row, col}];
		r.overflow_seen = overflow_model;
		cell_charge[{row, col}] = '0;
		expected_cells.insert(expected_cells.size(), r);
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic frac_t pick_frac();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return '1;
			2: return 16'h8000;
			default: return frac_t'($urandom);
		endcase
	endfunction

	function automatic void queue_particle(logic mode, logic [22:0] px, logic [22:0] py,
			grid_idx_t row, grid_idx_t col);
		particle_item_t it;
		it.mode = mode;
		it.pos_x = px;
		it.pos_y = py;
		it.cell_row = row;
		it.cell_col = col;
		pending_particles.insert(pending_particles.size(), it);
		issued_items++;
	endfunction

	// particles dropped around one spot, then cells of that spot read back, at times followed by one random item
	function automatic void queue_cluster();
		grid_idx_t base_x, base_y, cx, cy;
		int        n;
		base_x = grid_idx_t'($urandom);
		base_y = grid_idx_t'($urandom);
		n = $urandom_range(1, 8);
		for (int k = 0; k < n; k++) begin
			cx = base_x + grid_idx_t'($urandom_range(0, 2));
			cy = base_y + grid_idx_t'($urandom_range(0, 2));
			queue_particle(MODE_DEPOSIT, {cx, pick_frac()}, {cy, pick_frac()},
				grid_idx_t'($urandom), grid_idx_t'($urandom));
		end
		n = $urandom_range(1, 8);
		for (int k = 0; k < n; k++) begin
			cx = base_x + grid_idx_t'($urandom_range(0, 3));
			cy = base_y + grid_idx_t'($urandom_range(0, 3));
			queue_particle(MODE_READ, 23'($urandom), 23'($urandom), cx, cy);
		end
		if ($urandom_range(0, 2) == 0)
			queue_particle(logic'($urandom_range(0, 1)), 23'($urandom), 23'($urandom),
				grid_idx_t'($urandom), grid_idx_t'($urandom));
	endfunction

	function automatic void queue_random_phase(int count);
		int start;
		start = issued_items;
		while (issued_items - start < count)
			queue_cluster();
	endfunction

	task automatic wait_idle();
		while (accepted_items != issued_items || expected_cells.size() != 0)
			@(negedge clk);
		// deposits leave no result behind, so give the pipeline time to empty
		repeat (16) @(negedge clk);
	endtask

	task automatic write_charge(logic [CHARGE_BITS-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		charge_setting = value;
		charge_settings++;
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_particles.size() > 0) begin
				next_item = pending_particles.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {4'b0, next_item.cell_col, next_item.cell_row,
					next_item.pos_y, next_item.pos_x};
				s_axis_tuser <= next_item.mode;
				if (send_quiet > 0)
					send_quiet--;
				else if ($urandom_range(0, 49) == 0)
					send_quiet = $urandom_range(20, 80);
				else
					send_gap = pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (stall_left > 0)
				stall_left--;
			else if (ready_quiet > 0)
				ready_quiet--;
			else if ($urandom_range(0, 49) == 0)
				ready_quiet = $urandom_range(20, 80);
			else if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
			m_axis_tready <= (stall_left == 0);
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_cells.size() == 0) begin
					$error("result with none pending: cell_value %0h overflow_seen %0b",
						m_axis_tdata, m_axis_tuser);
					mismatches++;
				end else begin
					want = expected_cells.pop_front();
					if (m_axis_tdata !== want.cell_value) begin
						$error("cell_value expected %0h actual %0h", want.cell_value, m_axis_tdata);
						mismatches++;
					end
					if (m_axis_tuser !== want.overflow_seen) begin
						$error("overflow_seen expected %0b actual %0b",
							want.overflow_seen, m_axis_tuser);
						mismatches++;
					end
					reads_checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				accepted_items++;
				if (s_axis_tuser == MODE_READ) begin
					read_and_clear(s_axis_tdata[ROW_LSB +: GRID_BITS],
						s_axis_tdata[COL_LSB +: GRID_BITS]);
				end else begin
					deposit_particle(s_axis_tdata[POS_X_LSB +: POS_BITS],
						s_axis_tdata[POS_Y_LSB +: POS_BITS]);
					deposits_seen++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		@(posedge arst_n);

		// reset charge: corners, wrap of the upper cell, half and tiny fractions
		queue_particle(MODE_DEPOSIT, 23'h000000, 23'h000000, '1, '1);
		queue_particle(MODE_DEPOSIT, 23'h7FFFFF, 23'h7FFFFF, '0, '0);
		queue_particle(MODE_DEPOSIT, 23'h7F8000, 23'h008000, '1, '0);
		queue_particle(MODE_DEPOSIT, 23'h000000, 23'h7FFFFF, '0, '1);
		queue_particle(MODE_DEPOSIT, 23'h010001, 23'h01FFFF, '1, '1);
		queue_particle(MODE_READ, 23'h7FFFFF, 23'h7FFFFF, 7'd0, 7'd0);
		queue_particle(MODE_READ, 23'h000000, 23'h000000, 7'd0, 7'd127);
		queue_particle(MODE_READ, 23'h7FFFFF, 23'h000000, 7'd127, 7'd0);
		queue_particle(MODE_READ, 23'h000000, 23'h7FFFFF, 7'd127, 7'd127);
		queue_particle(MODE_READ, 23'h000000, 23'h000000, 7'd0, 7'd1);
		queue_particle(MODE_READ, 23'h000000, 23'h000000, 7'd1, 7'd0);
		queue_particle(MODE_READ, 23'h000000, 23'h000000, 7'd1, 7'd1);
		queue_particle(MODE_READ, 23'h000000, 23'h000000, 7'd1, 7'd2);
		queue_particle(MODE_READ, 23'h000000, 23'h000000, 7'd2, 7'd1);
		queue_particle(MODE_READ, 23'h000000, 23'h000000, 7'd2, 7'd2);
		queue_particle(MODE_READ, 23'h000000, 23'h000000, 7'd127, 7'd1);
		// a cleared cell and one never touched
		queue_particle(MODE_READ, 23'h000000, 23'h000000, 7'd0, 7'd0);
		queue_particle(MODE_READ, 23'h000000, 23'h000000, 7'd64, 7'd64);
		wait_idle();

		queue_random_phase(250);
		wait_idle();

		write_charge('0);
		queue_random_phase(200);
		wait_idle();

		write_charge('1);
		queue_random_phase(300);
		wait_idle();

		write_charge(CHARGE_BITS'($urandom));
		queue_random_phase(250);
		wait_idle();

		// smallest nonzero charge makes the rounding of each share visible
		write_charge(16'd1);
		queue_random_phase(250);
		wait_idle();

		write_charge(CHARGE_BITS'($urandom));
		queue_random_phase(250);
		wait_idle();

		write_charge(CHARGE_RESET);
		queue_random_phase(150);
		wait_idle();

		$display("%0d deposits and %0d read results checked over %0d charge settings",
			deposits_seen, reads_checked, charge_settings);
		$display("clustered deposits with wrap at the grid edges and random stalls on both sides");
		if (mismatches == 0) begin
			$display("cloud_in_cell_charge_deposit regression: pass");
		end else begin
			$display("cloud_in_cell_charge_deposit regression: fail");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("cloud_in_cell_charge_deposit regression: fail");
		$finish;
	end

endmodule
